@@ sv/ppu_pkg.sv @@
// ============================================================================
// ppu_pkg: shared types and constants of the particle pool update block
// Register indexes, fixed-point limits and the tick command passed from the
// front end to the back end.
// ============================================================================
`default_nettype none

package ppu_pkg;

    localparam int NUM_SLOTS  = 64;
    localparam int SLOT_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_LOOPING   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIFETIME  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR    = 3'd7;

    localparam logic [19:0] ACC_MAX   = 20'hFFFFF;
    localparam logic [31:0] LFSR_SEED = 32'h0000ACE1;
    localparam logic [31:0] LFSR_TAPS = 32'hA3000000;
    localparam logic [12:0] ONE_Q12   = 13'd4096;
    localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] POS_MIN = -24'sh800000;

    // One accepted tick, classified by the front end.
    typedef struct packed {
        logic        active;    // looping was on: age and move the pool
        logic [6:0]  n_emit;    // emissions requested, at most NUM_SLOTS
        logic [15:0] dt;
        logic signed [23:0] org_x;
        logic signed [23:0] org_y;
        logic signed [23:0] org_z;
    } tick_cmd_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_EMIT_FIND,
        BK_EMIT_RAND,
        BK_EMIT_MUL,
        BK_EMIT_WR,
        BK_UPD_RD,
        BK_UPD_MUL,
        BK_UPD_DIV,
        BK_UPD_WR,
        BK_OUT
    } back_state_t;

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        if (v > 48'(POS_MAX)) begin
            return POS_MAX;
        end
        if (v < 48'(POS_MIN)) begin
            return POS_MIN;
        end
        return v[23:0];
    endfunction

    function automatic logic [31:0] lfsr_step(input logic [31:0] s);
        logic [31:0] r;
        r = s >> 1;
        if (s[0]) begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/ppu_front.sv @@
// ============================================================================
// ppu_front: tick intake and emission count
// Holds the configuration registers and the emission accumulator, and turns
// each tick into a command: the accumulator division runs one quotient bit
// per cycle.
// ============================================================================
`default_nettype none

module ppu_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [15:0]                   delta_time,
    input  wire logic signed [23:0]            origin_x,
    input  wire logic signed [23:0]            origin_y,
    input  wire logic signed [23:0]            origin_z,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ppu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ppu_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [15:0]                        lifetime,
    output logic [47:0]                        direction,
    output logic [15:0]                        speed,
    output logic [15:0]                        spread,
    output logic                               cmd_valid,
    input  wire logic                          cmd_ready,
    output ppu_pkg::tick_cmd_t                 cmd
);

    logic        looping_reg;
    logic [15:0] interval_reg;
    logic [15:0] lifetime_reg;
    logic [47:0] direction_reg;
    logic [15:0] speed_reg;
    logic [15:0] spread_reg;
    logic [19:0] acc_reg;

    // Restoring division of the accumulator by the interval.
    logic        busy_reg;
    logic [4:0]  bit_reg;
    logic [19:0] quo_reg;
    logic [19:0] rem_reg;
    logic [19:0] dvd_reg;
    logic        cmd_valid_reg;
    ppu_pkg::tick_cmd_t cmd_reg;

    logic        accept;
    logic [20:0] acc_sum;
    logic [19:0] acc_sat;
    logic [20:0] rem_shift;
    logic        fits;

    assign full      = busy_reg || cmd_valid_reg;
    assign accept    = push && !full;
    assign cfg_ready = 1'b1;
    assign acc_sum   = {1'b0, acc_reg} + 21'(delta_time);
    assign acc_sat   = acc_sum[20] ? ppu_pkg::ACC_MAX : acc_sum[19:0];
    assign rem_shift = {rem_reg, dvd_reg[19]};
    assign fits      = rem_shift >= 21'(interval_reg);

    assign lifetime  = lifetime_reg;
    assign direction = direction_reg;
    assign speed     = speed_reg;
    assign spread    = spread_reg;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            looping_reg   <= 1'b1;
            interval_reg  <= 16'd410;
            lifetime_reg  <= 16'd8192;
            direction_reg <= 48'd4096;
            speed_reg     <= 16'd256;
            spread_reg    <= 16'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                ppu_pkg::REG_LOOPING:   looping_reg   <= cfg_data[0];
                ppu_pkg::REG_INTERVAL:  interval_reg  <= cfg_data[15:0];
                ppu_pkg::REG_LIFETIME:  lifetime_reg  <= cfg_data[15:0];
                ppu_pkg::REG_DIRECTION: direction_reg <= cfg_data;
                ppu_pkg::REG_SPEED:     speed_reg     <= cfg_data[15:0];
                ppu_pkg::REG_SPREAD:    spread_reg    <= cfg_data[15:0];
                // Size and colour of new particles never reach the results.
                ppu_pkg::REG_SIZE:      ;
                ppu_pkg::REG_COLOUR:    ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            acc_reg       <= '0;
            busy_reg      <= 1'b0;
            cmd_valid_reg <= 1'b0;
            bit_reg       <= '0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            cmd_reg       <= '0;
        end else begin
            if (cmd_valid_reg && cmd_ready) begin
                cmd_valid_reg <= 1'b0;
            end
            if (accept) begin
                cmd_reg.dt     <= delta_time;
                cmd_reg.org_x  <= origin_x;
                cmd_reg.org_y  <= origin_y;
                cmd_reg.org_z  <= origin_z;
                cmd_reg.active <= looping_reg;
                cmd_reg.n_emit <= '0;
                if (looping_reg && interval_reg != 16'd0) begin
                    busy_reg <= 1'b1;
                    bit_reg  <= 5'd19;
                    dvd_reg  <= acc_sat;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                end else begin
                    if (looping_reg) begin
                        acc_reg <= acc_sat;
                    end
                    cmd_valid_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                dvd_reg <= {dvd_reg[18:0], 1'b0};
                quo_reg <= {quo_reg[18:0], fits};
                rem_reg <= fits ? 20'(rem_shift - 21'(interval_reg)) : rem_shift[19:0];
                if (bit_reg == 5'd0) begin
                    busy_reg      <= 1'b0;
                    cmd_valid_reg <= 1'b1;
                    acc_reg       <= fits ? 20'(rem_shift - 21'(interval_reg))
                                          : rem_shift[19:0];
                    if ({quo_reg[18:0], fits} > 20'(ppu_pkg::NUM_SLOTS)) begin
                        cmd_reg.n_emit <= 7'(ppu_pkg::NUM_SLOTS);
                    end else begin
                        cmd_reg.n_emit <= {quo_reg[5:0], fits};
                    end
                end else begin
                    bit_reg <= bit_reg - 5'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/ppu_queue.sv @@
// ============================================================================
// ppu_queue: two-entry command queue
// Decouples tick intake from the pool walk.
// ============================================================================
`default_nettype none

module ppu_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ppu_pkg::tick_cmd_t in_cmd,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ppu_pkg::tick_cmd_t      out_cmd
);

    ppu_pkg::tick_cmd_t mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       wr;
    logic       rd;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_cmd   = mem_reg[rp_reg];
    assign wr        = in_valid && in_ready;
    assign rd        = out_valid && out_ready;

    always_ff @(posedge clk) begin
        if (wr) begin
            mem_reg[wp_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr) begin
                wp_reg <= !wp_reg;
            end
            if (rd) begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

endmodule

`default_nettype wire

@@ sv/ppu_back.sv @@
// ============================================================================
// ppu_back: pool walk
// Runs the emissions of one tick, then ages, moves and fades every slot and
// reports it. Per-slot state sits in small memories; alive flags are
// flip-flops.
// ============================================================================
`default_nettype none

module ppu_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire ppu_pkg::tick_cmd_t cmd,
    input  wire logic [15:0]        lifetime,
    input  wire logic [47:0]        direction,
    input  wire logic [15:0]        speed,
    input  wire logic [15:0]        spread,
    output logic                    empty,
    input  wire logic               pop,
    output logic [5:0]              slot_index,
    output logic                    slot_alive,
    output logic signed [23:0]      pos_x,
    output logic signed [23:0]      pos_y,
    output logic signed [23:0]      pos_z,
    output logic [12:0]             fade_alpha,
    output logic                    last_slot
);

    localparam int N = ppu_pkg::NUM_SLOTS;

    ppu_pkg::back_state_t state_reg, state_next;

    logic [N-1:0] alive_reg;
    logic [15:0]  age_mem  [N];
    logic [15:0]  life_mem [N];
    logic [71:0]  pos_mem  [N];
    logic [71:0]  vel_mem  [N];
    logic [12:0]  alpha_mem[N];

    ppu_pkg::tick_cmd_t cur_reg;
    logic [6:0]  left_reg;
    logic [5:0]  slot_reg;
    logic [1:0]  comp_reg;
    logic [31:0] lfsr_reg;
    logic signed [17:0] dsum_reg;
    logic signed [47:0] prod_reg;
    logic [71:0] vel_acc_reg;

    logic [15:0] age_rd_reg;
    logic [15:0] life_rd_reg;
    logic [71:0] pos_rd_reg;
    logic [71:0] vel_rd_reg;
    logic [12:0] alpha_rd_reg;
    logic        alive_rd_reg;
    logic [16:0] age_sum_reg;
    logic signed [47:0] step_reg [3];

    // Alpha divider: age*4096 / life, one quotient bit per cycle.
    logic [4:0]  dbit_reg;
    logic [27:0] dnum_reg;
    logic [16:0] drem_reg;
    logic [12:0] dquo_reg;

    logic        out_full_reg;

    logic        has_free;
    logic [5:0]  free_slot;
    logic signed [15:0] dir_c;
    logic [31:0] lfsr_n;
    logic [32:0] scaled;
    logic [17:0] mid;
    logic [17:0] drem_sh;
    logic        dfits;
    logic [71:0] pos_upd;

    always_comb begin
        has_free  = 1'b0;
        free_slot = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!alive_reg[i]) begin
                has_free  = 1'b1;
                free_slot = 6'(i);
            end
        end
    end

    always_comb begin
        case (comp_reg)
            2'd0:    dir_c = direction[15:0];
            2'd1:    dir_c = direction[31:16];
            default: dir_c = direction[47:32];
        endcase
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            pos_upd[24*c +: 24] = ppu_pkg::sat24(
                48'($signed(pos_rd_reg[24*c +: 24])) + (step_reg[c] >>> 12));
        end
    end

    assign lfsr_n  = ppu_pkg::lfsr_step(lfsr_reg);
    assign scaled  = {16'd0, spread, 1'b0} * 33'(lfsr_n[15:0]);
    assign mid     = 18'(scaled[32:16]);
    assign drem_sh = {drem_reg, dnum_reg[27]};
    assign dfits   = drem_sh >= 18'(life_rd_reg);

    assign cmd_ready = state_reg == ppu_pkg::BK_IDLE;
    assign empty     = !out_full_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ppu_pkg::BK_IDLE: begin
                if (cmd_valid) begin
                    state_next = ppu_pkg::BK_EMIT_FIND;
                end
            end
            ppu_pkg::BK_EMIT_FIND: begin
                if (left_reg != 7'd0 && has_free && cur_reg.active) begin
                    state_next = ppu_pkg::BK_EMIT_RAND;
                end else begin
                    state_next = ppu_pkg::BK_UPD_RD;
                end
            end
            ppu_pkg::BK_EMIT_RAND: state_next = ppu_pkg::BK_EMIT_MUL;
            ppu_pkg::BK_EMIT_MUL: begin
                state_next = (comp_reg == 2'd2) ? ppu_pkg::BK_EMIT_WR
                                                : ppu_pkg::BK_EMIT_RAND;
            end
            ppu_pkg::BK_EMIT_WR: state_next = ppu_pkg::BK_EMIT_FIND;
            ppu_pkg::BK_UPD_RD: begin
                if (!out_full_reg) begin
                    state_next = ppu_pkg::BK_UPD_MUL;
                end
            end
            ppu_pkg::BK_UPD_MUL: state_next = ppu_pkg::BK_UPD_DIV;
            ppu_pkg::BK_UPD_DIV: begin
                if (dbit_reg == 5'd0) begin
                    state_next = ppu_pkg::BK_UPD_WR;
                end
            end
            ppu_pkg::BK_UPD_WR: state_next = ppu_pkg::BK_OUT;
            ppu_pkg::BK_OUT: begin
                state_next = (slot_reg == 6'(N - 1)) ? ppu_pkg::BK_IDLE
                                                    : ppu_pkg::BK_UPD_RD;
            end
            default: state_next = ppu_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= ppu_pkg::BK_IDLE;
            alive_reg    <= '0;
            lfsr_reg     <= ppu_pkg::LFSR_SEED;
            out_full_reg <= 1'b0;
            slot_reg     <= '0;
            comp_reg     <= '0;
            left_reg     <= '0;
            dsum_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (out_full_reg && pop) begin
                out_full_reg <= 1'b0;
            end
            case (state_reg)
                ppu_pkg::BK_IDLE: begin
                    if (cmd_valid) begin
                        left_reg <= cmd.n_emit;
                        slot_reg <= '0;
                    end
                end
                ppu_pkg::BK_EMIT_FIND: begin
                    comp_reg <= '0;
                    if (left_reg == 7'd0 || !has_free || !cur_reg.active) begin
                        slot_reg <= '0;
                    end else begin
                        slot_reg <= free_slot;
                    end
                end
                ppu_pkg::BK_EMIT_RAND: begin
                    lfsr_reg <= lfsr_n;
                    dsum_reg <= 18'(dir_c) - 18'(spread) + $signed(mid);
                end
                ppu_pkg::BK_EMIT_MUL: begin
                    comp_reg <= comp_reg + 2'd1;
                end
                ppu_pkg::BK_EMIT_WR: begin
                    alive_reg[slot_reg] <= 1'b1;
                    left_reg <= left_reg - 7'd1;
                end
                ppu_pkg::BK_UPD_DIV: begin
                    if (alive_rd_reg && cur_reg.active && age_sum_reg >= 17'(life_rd_reg)) begin
                        alive_reg[slot_reg] <= 1'b0;
                    end
                end
                ppu_pkg::BK_OUT: begin
                    out_full_reg <= 1'b1;
                    slot_reg     <= slot_reg + 6'd1;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers and memories.
    always_ff @(posedge clk) begin
        case (state_reg)
            ppu_pkg::BK_IDLE: begin
                cur_reg <= cmd;
            end
            ppu_pkg::BK_EMIT_MUL: begin
                prod_reg <= 48'(dsum_reg) * $signed({32'd0, speed});
            end
            ppu_pkg::BK_EMIT_WR: begin
                age_mem[slot_reg]   <= '0;
                life_mem[slot_reg]  <= lifetime;
                alpha_mem[slot_reg] <= ppu_pkg::ONE_Q12;
                pos_mem[slot_reg]   <= {cur_reg.org_z, cur_reg.org_y, cur_reg.org_x};
                vel_mem[slot_reg]   <= {ppu_pkg::sat24(prod_reg >>> 8),
                                        vel_acc_reg[71:24]};
            end
            ppu_pkg::BK_UPD_RD: begin
                age_rd_reg   <= age_mem[slot_reg];
                life_rd_reg  <= life_mem[slot_reg];
                pos_rd_reg   <= pos_mem[slot_reg];
                vel_rd_reg   <= vel_mem[slot_reg];
                alpha_rd_reg <= alpha_mem[slot_reg];
                alive_rd_reg <= alive_reg[slot_reg];
            end
            ppu_pkg::BK_UPD_MUL: begin
                age_sum_reg <= 17'(age_rd_reg) + 17'(cur_reg.dt);
                for (int c = 0; c < 3; c++) begin
                    step_reg[c] <= 48'($signed(vel_rd_reg[24*c +: 24]))
                                   * $signed({32'd0, cur_reg.dt});
                end
                dbit_reg <= 5'd27;
                drem_reg <= '0;
                dquo_reg <= '0;
                dnum_reg <= {age_rd_reg + cur_reg.dt, 12'd0};
            end
            ppu_pkg::BK_UPD_DIV: begin
                dnum_reg <= {dnum_reg[26:0], 1'b0};
                dquo_reg <= {dquo_reg[11:0], dfits};
                drem_reg <= dfits ? 17'(drem_sh - 18'(life_rd_reg)) : drem_sh[16:0];
                dbit_reg <= dbit_reg - 5'd1;
            end
            ppu_pkg::BK_UPD_WR: begin
                if (alive_rd_reg && cur_reg.active && age_sum_reg < 17'(life_rd_reg)) begin
                    age_mem[slot_reg]   <= age_sum_reg[15:0];
                    alpha_mem[slot_reg] <= ppu_pkg::ONE_Q12 - dquo_reg;
                    alpha_rd_reg        <= ppu_pkg::ONE_Q12 - dquo_reg;
                    pos_rd_reg          <= pos_upd;
                    pos_mem[slot_reg]   <= pos_upd;
                end
            end
            ppu_pkg::BK_OUT: begin
                slot_index <= slot_reg;
                slot_alive <= alive_reg[slot_reg];
                last_slot  <= slot_reg == 6'(N - 1);
                pos_x      <= alive_reg[slot_reg] ? pos_rd_reg[23:0]  : '0;
                pos_y      <= alive_reg[slot_reg] ? pos_rd_reg[47:24] : '0;
                pos_z      <= alive_reg[slot_reg] ? pos_rd_reg[71:48] : '0;
                fade_alpha <= alive_reg[slot_reg] ? alpha_rd_reg : '0;
            end
            default: ;
        endcase
        if (state_reg == ppu_pkg::BK_EMIT_MUL && comp_reg != 2'd2) begin
            vel_acc_reg <= {ppu_pkg::sat24(48'(dsum_reg) * $signed({32'd0, speed}) >>> 8),
                            vel_acc_reg[71:24]};
        end
    end

endmodule

`default_nettype wire

@@ sv/particle_pool_update.sv @@
// ============================================================================
// particle_pool_update: fixed-point particle emitter pool
// Top level: tick intake front end, command queue and pool walk back end.
// ============================================================================
// Ticks enter through push/full and carry a time step and an emitter origin.
// Each tick gives 64 results, one per slot in order, read through empty/pop;
// last_slot marks the final one. Configuration is written through cfg_valid/
// cfg_ready with a register index and data; the user must write it only while
// the block is idle, which the block itself does not enforce. The front end
// divides the emission accumulator bit-serially; the back end handles each
// emission with a free slot search, three random draws and multiplies, and a
// write, and each slot with a read, a multiply, the bit-serial alpha divider,
// a write-back and an output step.
// A command queue of two ticks sits between front and back end, so the next
// tick may be accepted while the pool is still walked.
// If pop stays low, the single output register holds its result and the
// pool walk waits before the next slot; nothing is lost.
// Reset empties the pool, clears the accumulator, seeds the random generator
// and loads the register defaults; no clearing pass is needed.
// ============================================================================
`default_nettype none

module particle_pool_update (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [15:0]                     delta_time,
    input  wire logic signed [23:0]              origin_x,
    input  wire logic signed [23:0]              origin_y,
    input  wire logic signed [23:0]              origin_z,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [5:0]                           slot_index,
    output logic                                 slot_alive,
    output logic signed [23:0]                   pos_x,
    output logic signed [23:0]                   pos_y,
    output logic signed [23:0]                   pos_z,
    output logic [12:0]                          fade_alpha,
    output logic                                 last_slot,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ppu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ppu_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [15:0] lifetime;
    logic [47:0] direction;
    logic [15:0] speed;
    logic [15:0] spread;
    logic        f_valid, f_ready, b_valid, b_ready;
    ppu_pkg::tick_cmd_t f_cmd, b_cmd;

    ppu_front u_front (
        .clk, .rst_n, .push, .full, .delta_time, .origin_x, .origin_y, .origin_z,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .lifetime, .direction, .speed, .spread,
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    ppu_queue u_queue (
        .clk, .rst_n,
        .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
        .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd)
    );

    ppu_back u_back (
        .clk, .rst_n,
        .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
        .lifetime, .direction, .speed, .spread,
        .empty, .pop, .slot_index, .slot_alive, .pos_x, .pos_y, .pos_z,
        .fade_alpha, .last_slot
    );

endmodule

`default_nettype wire
